@@ hw/rtl/ght_pkg.sv @@
// Shared types and constants for the generation-tagged handle table.
// Token field layout, status and operation codes, controller/datapath interface structs.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ght_pkg;

	localparam int unsigned SLOT_BITS            = 20;
	localparam int unsigned TYPE_BITS            = 5;
	localparam int unsigned TOKEN_GEN_BITS       = 31;
	localparam int unsigned GEN_BITS             = 32;
	localparam int unsigned TOKEN_BITS           = 56;
	localparam int unsigned TYPE_LSB             = SLOT_BITS;
	localparam int unsigned GEN_LSB              = SLOT_BITS + TYPE_BITS;
	localparam int unsigned PAYLOAD_PORT_BITS    = 32;
	localparam int unsigned LIVE_OUT_BITS        = 11;
	localparam int unsigned TYPE_COUNT_BITS      = 6;
	localparam int unsigned STATUS_BITS          = 3;
	localparam int unsigned KIND_BITS            = 2;
	localparam int unsigned DEFAULT_TABLE_DEPTH  = 1024;
	localparam int unsigned DEFAULT_PAYLOAD_BITS = 32;

	localparam logic [TYPE_COUNT_BITS-1:0] TYPE_COUNT_RESET = 6'd32;

	typedef enum logic [KIND_BITS-1:0] {
		KIND_MINT    = 2'd0,
		KIND_BORROW  = 2'd1,
		KIND_RESOLVE = 2'd2,
		KIND_CLOSE   = 2'd3
	} kind_t;

	typedef enum logic [STATUS_BITS-1:0] {
		ST_OK      = 3'd0,
		ST_BAD_ARG = 3'd1,
		ST_FULL    = 3'd2,
		ST_STALE   = 3'd3,
		ST_INVALID = 3'd4
	} status_t;

	// controller -> datapath
	typedef struct packed {
		logic    clear_wr;
		logic    capture;
		logic    rd_token;
		logic    scan_init;
		logic    probe;
		logic    sweep;
		logic    mint_wr;
		logic    free;
		logic    pop;
		logic    take_payload;
		logic    status_we;
		status_t status;
		logic    load_out;
	} ght_cmd_t;

	// datapath -> controller
	typedef struct packed {
		kind_t kind;
		logic  cnt_last;
		logic  pay_zero;
		logic  tok_zero;
		logic  type_bad;
		logic  slot_bad;
		logic  tok_match;
		logic  probe_hit;
		logic  sweep_hit;
		logic  scan_end;
		logic  stack_empty;
	} ght_stat_t;

endpackage

`default_nettype wire

@@ hw/rtl/generation_tagged_handle_table.sv @@
// Top level of the generation-tagged handle table.
// Instantiates ght_ctrl and ght_dp; uses ght_pkg.
//
//  channel  | handshake            | payload
//  ---------+----------------------+------------------------------------------
//  request  | in_valid / in_ready  | kind, object_type, payload, token
//  result   | out_valid / out_ready| token_out, payload_out, status, live_count
//  config   | cfg_we               | cfg_data (type_count)
//
// After reset the entry table is cleared one slot a cycle; no request is taken until it is done.
// Resolve passes through capture, decode, check and finish. Mint goes from decode to next-fit
// probing, starting at the slot after the last mint, through the single entry memory read port,
// one slot a cycle; borrow passes through the check before it probes.
// Close runs a full sweep of the table for each entry freed (root plus descendants), and it
// finishes once it finds the work stack empty.
// One request is in flight at a time; a finished result waits in the output register
// while a new request is accepted, and a held result stalls only the next finish.
`timescale 1ns / 1ps
`default_nettype none

module generation_tagged_handle_table #(
	parameter int unsigned TABLE_DEPTH  = ght_pkg::DEFAULT_TABLE_DEPTH,
	parameter int unsigned PAYLOAD_BITS = ght_pkg::DEFAULT_PAYLOAD_BITS
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic [ght_pkg::KIND_BITS-1:0]         kind,
	input  logic [ght_pkg::TYPE_BITS-1:0]         object_type,
	input  logic [ght_pkg::PAYLOAD_PORT_BITS-1:0] payload,
	input  logic [ght_pkg::TOKEN_BITS-1:0]        token,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic [ght_pkg::TOKEN_BITS-1:0]        token_out,
	output logic [ght_pkg::PAYLOAD_PORT_BITS-1:0] payload_out,
	output logic [ght_pkg::STATUS_BITS-1:0]       status,
	output logic [ght_pkg::LIVE_OUT_BITS-1:0]     live_count,
	input  logic                                  cfg_we,
	input  logic [ght_pkg::TYPE_COUNT_BITS-1:0]   cfg_data
);
	import ght_pkg::*;

	ght_cmd_t  cmd;
	ght_stat_t st;

	ght_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.st        (st),
		.cmd       (cmd)
	);

	ght_dp #(
		.TABLE_DEPTH  (TABLE_DEPTH),
		.PAYLOAD_BITS (PAYLOAD_BITS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.st          (st),
		.cfg_we      (cfg_we),
		.cfg_data    (cfg_data),
		.kind        (kind),
		.object_type (object_type),
		.payload     (payload),
		.token       (token),
		.token_out   (token_out),
		.payload_out (payload_out),
		.status      (status),
		.live_count  (live_count)
	);

endmodule

`default_nettype wire

@@ hw/rtl/ght_ctrl.sv @@
// Sequencing FSM for the handle table: clear pass, decode, probe, close sweeps.
// Uses ght_pkg; drives the datapath through ght_cmd_t.
`timescale 1ns / 1ps
`default_nettype none

module ght_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	output logic             out_valid,
	input  logic             out_ready,
	input  ght_pkg::ght_stat_t st,
	output ght_pkg::ght_cmd_t  cmd
);
	import ght_pkg::*;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_DECODE,
		S_CHECK,
		S_PROBE,
		S_POP,
		S_POP_WAIT,
		S_SWEEP,
		S_FINISH
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			S_CLEAR: begin
				cmd.clear_wr = 1'b1;
				if (st.cnt_last) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = S_DECODE;
				end
			end
			S_DECODE: begin
				cmd.scan_init = 1'b1;
				cmd.rd_token  = 1'b1;
				unique case (st.kind) inside
					KIND_MINT: begin
						if (st.pay_zero || st.type_bad) begin
							cmd.status_we = 1'b1;
							cmd.status    = ST_BAD_ARG;
							state_d       = S_FINISH;
						end else begin
							state_d = S_PROBE;
						end
					end
					KIND_BORROW: begin
						if (st.pay_zero || st.tok_zero) begin
							cmd.status_we = 1'b1;
							cmd.status    = ST_BAD_ARG;
							state_d       = S_FINISH;
						end else if (st.slot_bad) begin
							cmd.status_we = 1'b1;
							cmd.status    = ST_STALE;
							state_d       = S_FINISH;
						end else begin
							state_d = S_CHECK;
						end
					end
					KIND_RESOLVE, KIND_CLOSE: begin
						if (st.tok_zero || st.slot_bad) begin
							cmd.status_we = 1'b1;
							cmd.status    = ST_INVALID;
							state_d       = S_FINISH;
						end else begin
							state_d = S_CHECK;
						end
					end
				endcase
			end
			S_CHECK: begin
				cmd.scan_init = 1'b1;
				unique case (st.kind) inside
					// plain mint never reaches this state
					KIND_MINT, KIND_BORROW: begin
						if (!st.tok_match) begin
							cmd.status_we = 1'b1;
							cmd.status    = ST_STALE;
							state_d       = S_FINISH;
						end else if (st.type_bad) begin
							cmd.status_we = 1'b1;
							cmd.status    = ST_BAD_ARG;
							state_d       = S_FINISH;
						end else begin
							state_d = S_PROBE;
						end
					end
					KIND_RESOLVE: begin
						cmd.status_we = 1'b1;
						state_d       = S_FINISH;
						if (st.tok_match) begin
							cmd.status       = ST_OK;
							cmd.take_payload = 1'b1;
						end else begin
							cmd.status = ST_INVALID;
						end
					end
					KIND_CLOSE: begin
						cmd.status_we = 1'b1;
						if (st.tok_match) begin
							cmd.status       = ST_OK;
							cmd.take_payload = 1'b1;
							cmd.free         = 1'b1;
							state_d          = S_POP;
						end else begin
							cmd.status = ST_INVALID;
							state_d    = S_FINISH;
						end
					end
				endcase
			end
			S_PROBE: begin
				if (st.probe_hit) begin
					cmd.mint_wr   = 1'b1;
					cmd.status_we = 1'b1;
					cmd.status    = ST_OK;
					state_d       = S_FINISH;
				end else if (st.scan_end) begin
					cmd.status_we = 1'b1;
					cmd.status    = ST_FULL;
					state_d       = S_FINISH;
				end else begin
					cmd.probe = 1'b1;
				end
			end
			S_POP: begin
				if (st.stack_empty) begin
					state_d = S_FINISH;
				end else begin
					cmd.pop = 1'b1;
					state_d = S_POP_WAIT;
				end
			end
			S_POP_WAIT: begin
				cmd.scan_init = 1'b1;
				state_d       = S_SWEEP;
			end
			S_SWEEP: begin
				cmd.sweep = 1'b1;
				cmd.free  = st.sweep_hit;
				if (st.scan_end) state_d = S_POP;
			end
			S_FINISH: begin
				if (!out_valid_q || out_ready) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

@@ hw/rtl/ght_dp.sv @@
// Datapath of the handle table: entry memory, close work stack, counters, result registers.
// Uses ght_pkg; commanded by ght_ctrl.
`timescale 1ns / 1ps
`default_nettype none

module ght_dp #(
	parameter int unsigned TABLE_DEPTH  = ght_pkg::DEFAULT_TABLE_DEPTH,
	parameter int unsigned PAYLOAD_BITS = ght_pkg::DEFAULT_PAYLOAD_BITS
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  ght_pkg::ght_cmd_t                      cmd,
	output ght_pkg::ght_stat_t                     st,
	input  logic                                   cfg_we,
	input  logic [ght_pkg::TYPE_COUNT_BITS-1:0]    cfg_data,
	input  logic [ght_pkg::KIND_BITS-1:0]          kind,
	input  logic [ght_pkg::TYPE_BITS-1:0]          object_type,
	input  logic [ght_pkg::PAYLOAD_PORT_BITS-1:0]  payload,
	input  logic [ght_pkg::TOKEN_BITS-1:0]         token,
	output logic [ght_pkg::TOKEN_BITS-1:0]         token_out,
	output logic [ght_pkg::PAYLOAD_PORT_BITS-1:0]  payload_out,
	output logic [ght_pkg::STATUS_BITS-1:0]        status,
	output logic [ght_pkg::LIVE_OUT_BITS-1:0]      live_count
);
	import ght_pkg::*;

	localparam int unsigned AW = $clog2(TABLE_DEPTH);
	localparam int unsigned CW = AW + 1;
	localparam int unsigned PX = (PAYLOAD_BITS > PAYLOAD_PORT_BITS) ? PAYLOAD_BITS
		: PAYLOAD_PORT_BITS;
	localparam int unsigned LX = (CW > LIVE_OUT_BITS) ? CW : LIVE_OUT_BITS;
	localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);
	localparam logic [CW-1:0] NO_PARENT = DEPTH_C;
	localparam logic [AW-1:0] LAST_SLOT = AW'(TABLE_DEPTH - 1);
	localparam logic [SLOT_BITS:0] DEPTH_S = (SLOT_BITS + 1)'(TABLE_DEPTH);

	typedef struct packed {
		logic [PAYLOAD_BITS-1:0] pay;
		logic [GEN_BITS-1:0]     gen;
		logic [TYPE_BITS-1:0]    typ;
		logic [CW-1:0]           par;
		logic [GEN_BITS-1:0]     pgen;
	} entry_t;

	typedef struct packed {
		logic [AW-1:0]       slot;
		logic [GEN_BITS-1:0] gen;
	} work_t;

	entry_t ent_mem [TABLE_DEPTH];
	work_t  stk_mem [TABLE_DEPTH];

	kind_t                    kind_q;
	logic [TYPE_BITS-1:0]     typ_q;
	logic [PAYLOAD_BITS-1:0]  pay_q;
	logic [TOKEN_BITS-1:0]    tok_q;
	logic [TYPE_COUNT_BITS-1:0] type_count_q;

	logic [CW-1:0] cnt_q, live_q, top_q;
	logic [AW-1:0] pa_q, scan_q, addr_s1;
	logic          v_s1;
	entry_t        rd_s1;
	work_t         stk_rd_q;

	logic [TOKEN_BITS-1:0]        res_tok_q, tok_out_q;
	logic [PAYLOAD_PORT_BITS-1:0] res_pay_q, pay_out_q;
	status_t                      res_status_q, status_q;
	logic [LIVE_OUT_BITS-1:0]     live_out_q;

	logic [PX-1:0]        pay_in_x, pay_rd_x;
	logic [LX-1:0]        live_x;
	logic [TYPE_BITS-1:0] tok_typ, want_typ;
	logic [GEN_BITS-1:0]  tok_gen, gen_new;
	logic                 scan_issue, rd_en, wr_en, ent_live;
	logic [AW-1:0]        rd_addr, wr_addr;
	logic [CW-1:0]        top_m1;
	entry_t               wr_data;

	assign pay_in_x = PX'(payload);
	assign pay_rd_x = PX'(rd_s1.pay);
	assign live_x   = LX'(live_q);
	assign tok_typ  = tok_q[GEN_LSB-1:TYPE_LSB];
	assign tok_gen  = GEN_BITS'(tok_q[TOKEN_BITS-1:GEN_LSB]);
	assign want_typ = (kind_q == KIND_BORROW) ? tok_typ : typ_q;
	// a slot claimed by mint has an even generation, so +1 makes it odd; a free makes it even again
	assign gen_new  = rd_s1.gen + 1'b1;
	assign ent_live = (rd_s1.pay != '0) && rd_s1.gen[0];
	assign top_m1   = top_q - 1'b1;

	assign scan_issue = (cmd.probe || cmd.sweep) && (cnt_q != DEPTH_C);

	always_comb begin
		rd_en   = 1'b0;
		rd_addr = pa_q;
		if (cmd.rd_token) begin
			rd_en   = 1'b1;
			rd_addr = tok_q[AW-1:0];
		end else if (scan_issue) begin
			rd_en   = 1'b1;
			rd_addr = cmd.sweep ? cnt_q[AW-1:0] : pa_q;
		end
	end

	always_comb begin
		wr_en   = 1'b1;
		wr_addr = addr_s1;
		wr_data = '{pay: '0, gen: gen_new, typ: '0, par: NO_PARENT, pgen: '0};
		if (cmd.clear_wr) begin
			wr_addr = cnt_q[AW-1:0];
			wr_data = '{pay: '0, gen: '0, typ: '0, par: NO_PARENT, pgen: '0};
		end else if (cmd.mint_wr) begin
			wr_data.pay = pay_q;
			wr_data.typ = typ_q;
			if (kind_q == KIND_BORROW) begin
				wr_data.par  = CW'(tok_q[AW-1:0]);
				wr_data.pgen = tok_gen;
			end
		end else if (!cmd.free) begin
			wr_en = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) ent_mem[wr_addr] <= wr_data;
		if (rd_en) begin
			rd_s1   <= ent_mem[rd_addr];
			addr_s1 <= rd_addr;
		end
	end

	// work stack of entries freed by a close whose children are still to be found
	always_ff @(posedge clk) begin
		if (cmd.free) stk_mem[top_q[AW-1:0]] <= '{slot: addr_s1, gen: rd_s1.gen};
		if (cmd.pop) stk_rd_q <= stk_mem[top_m1[AW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			kind_q <= kind_t'(kind);
			typ_q  <= object_type;
			pay_q  <= pay_in_x[PAYLOAD_BITS-1:0];
			tok_q  <= token;
		end
		if (cmd.capture) begin
			res_tok_q <= '0;
			res_pay_q <= '0;
		end else begin
			if (cmd.mint_wr)
				res_tok_q <= {gen_new[TOKEN_GEN_BITS-1:0], typ_q, SLOT_BITS'(addr_s1)};
			if (cmd.take_payload) res_pay_q <= pay_rd_x[PAYLOAD_PORT_BITS-1:0];
		end
		if (cmd.status_we) res_status_q <= cmd.status;
		if (cmd.load_out) begin
			tok_out_q  <= res_tok_q;
			pay_out_q  <= res_pay_q;
			status_q   <= res_status_q;
			live_out_q <= live_x[LIVE_OUT_BITS-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			type_count_q <= TYPE_COUNT_RESET;
			cnt_q        <= '0;
			pa_q         <= '0;
			scan_q       <= '0;
			v_s1         <= 1'b0;
			live_q       <= '0;
			top_q        <= '0;
		end else begin
			if (cfg_we) type_count_q <= cfg_data;
			v_s1 <= scan_issue;
			if (cmd.scan_init) cnt_q <= '0;
			else if (cmd.clear_wr || scan_issue) cnt_q <= cnt_q + 1'b1;
			if (cmd.scan_init) pa_q <= scan_q;
			else if (scan_issue && cmd.probe) pa_q <= (pa_q == LAST_SLOT) ? '0 : pa_q + 1'b1;
			if (cmd.mint_wr) begin
				scan_q <= (addr_s1 == LAST_SLOT) ? '0 : addr_s1 + 1'b1;
				live_q <= live_q + 1'b1;
			end else if (cmd.free && live_q != '0) begin
				live_q <= live_q - 1'b1;
			end
			if (cmd.free) top_q <= top_q + 1'b1;
			else if (cmd.pop) top_q <= top_m1;
		end
	end

	assign st.kind        = kind_q;
	assign st.cnt_last    = (cnt_q == DEPTH_C - 1'b1);
	assign st.pay_zero    = (pay_q == '0);
	assign st.tok_zero    = (tok_q == '0);
	assign st.type_bad    = (typ_q == '0) || ({1'b0, typ_q} >= type_count_q);
	assign st.slot_bad    = ({1'b0, tok_q[SLOT_BITS-1:0]} >= DEPTH_S);
	assign st.tok_match   = (rd_s1.pay != '0) && (rd_s1.gen == tok_gen) && (rd_s1.typ == want_typ);
	assign st.probe_hit   = v_s1 && (rd_s1.pay == '0) && !rd_s1.gen[0];
	assign st.sweep_hit   = v_s1 && ent_live && (rd_s1.par == CW'(stk_rd_q.slot))
		&& (rd_s1.pgen == stk_rd_q.gen);
	assign st.scan_end    = (cnt_q == DEPTH_C) && !v_s1;
	assign st.stack_empty = (top_q == '0);

	assign token_out   = tok_out_q;
	assign payload_out = pay_out_q;
	assign status      = status_q;
	assign live_count  = live_out_q;

endmodule

`default_nettype wire

@@ hw/rtl/ght_checker.sv @@
// Port-level checks for the handle table, attached by bind.
// Uses ght_pkg; binds to generation_tagged_handle_table.
`timescale 1ns / 1ps
`default_nettype none

module ght_checker #(
	parameter int unsigned TABLE_DEPTH = ght_pkg::DEFAULT_TABLE_DEPTH
) (
	input logic                                  clk,
	input logic                                  arst_n,
	input logic                                  out_valid,
	input logic                                  out_ready,
	input logic [ght_pkg::TOKEN_BITS-1:0]        token_out,
	input logic [ght_pkg::PAYLOAD_PORT_BITS-1:0] payload_out,
	input logic [ght_pkg::STATUS_BITS-1:0]       status,
	input logic [ght_pkg::LIVE_OUT_BITS-1:0]     live_count
);
	import ght_pkg::*;

	localparam logic [31:0] DEPTH_W = 32'(TABLE_DEPTH);

	// a held result's token and status must not change under a stall
	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(token_out) && $stable(status))
		else $error("result changed while stalled");

	// a minted token or a returned payload only comes with status ok
	a_data_means_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (token_out != '0 || payload_out != '0) |-> status == ST_OK)
		else $error("data returned with error status");

	// minted tokens carry an odd generation and a nonzero type
	a_token_form: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && token_out != '0
		|-> token_out[GEN_LSB] && token_out[GEN_LSB-1:TYPE_LSB] != '0)
		else $error("malformed token");

	// live count never exceeds the table (checked only for depths below 2048)
	a_live_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> 32'(live_count) <= DEPTH_W || TABLE_DEPTH >= 2048)
		else $error("live count above table depth");

endmodule

bind generation_tagged_handle_table ght_checker #(.TABLE_DEPTH(TABLE_DEPTH)) u_ght_checker (.*);

`default_nettype wire
